@@ rtl/nearest_target_snap_with_hysteresis_defines.svh @@
// ----------------------------------------------------------------------------
// nearest_target_snap_with_hysteresis_defines
// Assertion macros shared by the snap engine files.
// ----------------------------------------------------------------------------
`ifndef NEAREST_TARGET_SNAP_WITH_HYSTERESIS_DEFINES_SVH
`define NEAREST_TARGET_SNAP_WITH_HYSTERESIS_DEFINES_SVH

// same-cycle implication, held off while in reset
`define NTSH_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off while in reset
`define NTSH_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/ntsh_pkg.sv @@
// ----------------------------------------------------------------------------
// ntsh_pkg
// Operation codes, register indexes and common types of the snap engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ntsh_pkg;

    localparam int OP_W   = 3;
    localparam int KIND_W = 3;
    localparam int CFG_W  = 32;
    localparam int ADDR_W = 2;

    typedef logic [OP_W-1:0]   op_t;
    typedef logic [KIND_W-1:0] kind_t;
    typedef logic [ADDR_W-1:0] cfg_addr_t;

    // request operations
    localparam op_t OP_CLEAR      = 3'd0;
    localparam op_t OP_ADD        = 3'd1;
    localparam op_t OP_SNAP       = 3'd2;
    localparam op_t OP_SNAP_PAIR  = 3'd3;
    localparam op_t OP_LOCK_RESET = 3'd4;

    // configuration register indexes
    localparam cfg_addr_t CFG_SNAP_ENABLE   = 2'd0;
    localparam cfg_addr_t CFG_ATTRACT_TICKS = 2'd1;
    localparam cfg_addr_t CFG_RELEASE_TICKS = 2'd2;

    localparam kind_t KIND_GRID = 3'd0;

endpackage

@@ rtl/ntsh_dist.sv @@
// ----------------------------------------------------------------------------
// ntsh_dist
// Shared distance unit: registered unsigned magnitude of x - y for signed ticks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ntsh_dist #(
    parameter int TICK_BITS = 48
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic [TICK_BITS-1:0] x,
    input  logic [TICK_BITS-1:0] y,
    output logic [TICK_BITS-1:0] d_reg
);

    logic [TICK_BITS:0] diff_xy;
    logic [TICK_BITS:0] diff_yx;

    // both differences in parallel, one extra bit for the sign
    assign diff_xy = {x[TICK_BITS-1], x} - {y[TICK_BITS-1], y};
    assign diff_yx = {y[TICK_BITS-1], y} - {x[TICK_BITS-1], x};

    // pick the non-negative one; the magnitude always fits the tick width
    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= diff_xy[TICK_BITS] ? diff_yx[TICK_BITS-1:0] : diff_xy[TICK_BITS-1:0];
        end
    end

endmodule

@@ rtl/nearest_target_snap_with_hysteresis.sv @@
// ----------------------------------------------------------------------------
// nearest_target_snap_with_hysteresis
// Snap engine: nearest typed target within the attract zone, held by a lock
// until the probe leaves the release zone.
// ----------------------------------------------------------------------------
// clear, add and lock reset requests are done in idle and give no result
// snap held by the lock: lock checks, then the result; snap with scan: a table scan;
// snap pair with scan: two scans; a dropped lock first runs the lock checks; the
// scan reads one table entry per cycle through the single distance unit, A then B
// one request at a time; a finished result waits in the output register
// synchronous active-low reset clears the config, table count, lock, state and result valid
`timescale 1ns / 1ps

`include "nearest_target_snap_with_hysteresis_defines.svh"

module nearest_target_snap_with_hysteresis #(
    parameter int MAX_TARGETS = 256,
    parameter int TICK_BITS   = 48
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // configuration writes
    input  logic                                   cfg_wr_en,
    input  ntsh_pkg::cfg_addr_t                    cfg_addr,
    input  logic [ntsh_pkg::CFG_W-1:0]             cfg_wr_data,
    // request channel
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // tick_a, tick_b, zero fill
    input  logic [((2*TICK_BITS+7)/8)*8-1:0]       s_tdata,
    // op, kind_in
    input  logic [ntsh_pkg::OP_W+ntsh_pkg::KIND_W-1:0] s_tuser,
    // result channel
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // result_tick, delta, zero fill
    output logic [((2*TICK_BITS+7)/8)*8-1:0]       m_tdata,
    // snapped, kind_out
    output logic [ntsh_pkg::KIND_W:0]              m_tuser
);

    import ntsh_pkg::*;

    localparam int DATA_W = ((2*TICK_BITS+7)/8)*8;
    localparam int IW     = $clog2(MAX_TARGETS);
    localparam int CW     = $clog2(MAX_TARGETS+1);

    typedef struct packed {
        logic [TICK_BITS-1:0] tick;
        kind_t                kind;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOCK_A,
        ST_LOCK_B,
        ST_LOCK_CHK,
        ST_SCAN,
        ST_SCAN_END,
        ST_FIN,
        ST_EMIT
    } state_t;

    // configuration
    logic                 snap_en_reg;
    logic [CFG_W-1:0]     attract_reg;
    logic [CFG_W-1:0]     release_reg;
    logic [TICK_BITS-1:0] att_ext;
    logic [TICK_BITS-1:0] rel_ext;

    // request fields
    op_t                  in_op;
    kind_t                in_kind;
    logic [TICK_BITS-1:0] in_tick_a;
    logic [TICK_BITS-1:0] in_tick_b;
    logic                 in_acc;

    // control and table state
    state_t               state_reg;
    logic [CW-1:0]        count_reg;
    logic                 lock_valid_reg;
    logic [TICK_BITS-1:0] lock_tick_reg;
    kind_t                lock_kind_reg;

    // working registers of one request
    logic [TICK_BITS-1:0] a_reg;
    logic [TICK_BITS-1:0] b_reg;
    logic                 pair_reg;
    logic                 phase_reg;
    logic [TICK_BITS-1:0] la_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 v1_reg;
    logic                 v2_reg;
    entry_t               cand_reg;
    logic                 any_reg;
    logic [TICK_BITS-1:0] best_reg;
    entry_t               hit_reg;
    logic                 fa_reg;
    logic [TICK_BITS-1:0] da_reg;
    entry_t               ta_reg;
    logic [TICK_BITS-1:0] sel_tick_reg;
    kind_t                sel_kind_reg;
    logic                 use_b_reg;
    logic                 snapped_reg;
    logic [TICK_BITS-1:0] delta_reg;

    // output registers
    logic                 m_tvalid_reg;
    logic [DATA_W-1:0]    m_tdata_reg;
    logic [KIND_W:0]      m_tuser_reg;

    // table memory
    entry_t               mem [MAX_TARGETS];
    entry_t               mem_q_reg;
    logic [IW-1:0]        rd_addr;
    logic                 mem_we;

    // shared distance unit
    logic                 dist_en;
    logic [TICK_BITS-1:0] dist_x;
    logic [TICK_BITS-1:0] dist_y;
    logic [TICK_BITS-1:0] dist_d;

    // decision helpers
    logic                 issue;
    logic                 pass_thru;
    logic                 la_ok;
    logic                 lb_ok;
    logic                 lock_hit;
    logic                 lock_use_b;
    logic                 found_now;
    logic                 fa;
    logic                 fb;
    logic                 pick_a;
    entry_t               a_cand;
    entry_t               win;

    // field unpacking
    assign in_op     = s_tuser[OP_W-1:0];
    assign in_kind   = s_tuser[OP_W+KIND_W-1:OP_W];
    assign in_tick_a = s_tdata[TICK_BITS-1:0];
    assign in_tick_b = s_tdata[2*TICK_BITS-1:TICK_BITS];

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign att_ext = TICK_BITS'(attract_reg);
    assign rel_ext = TICK_BITS'(release_reg);

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snap_en_reg <= 1'b0;
            attract_reg <= '0;
            release_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_SNAP_ENABLE:   snap_en_reg <= cfg_wr_data[0];
                CFG_ATTRACT_TICKS: attract_reg <= cfg_wr_data;
                CFG_RELEASE_TICKS: release_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // table write on add, registered read for the scan
    assign mem_we  = in_acc && (in_op == OP_ADD) && (count_reg < CW'(MAX_TARGETS));
    assign rd_addr = cnt_reg[IW-1:0];

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[count_reg[IW-1:0]] <= '{tick: in_tick_a, kind: in_kind};
        end
        mem_q_reg <= mem[rd_addr];
    end

    // distance unit operands: lock checks first, then table entries
    always_comb begin
        dist_x = phase_reg ? b_reg : a_reg;
        dist_y = mem_q_reg.tick;
        case (state_reg)
            ST_LOCK_A: begin
                dist_x = a_reg;
                dist_y = lock_tick_reg;
            end
            ST_LOCK_B: begin
                dist_x = b_reg;
                dist_y = lock_tick_reg;
            end
            default: ;
        endcase
    end

    assign dist_en = (state_reg == ST_LOCK_A) || (state_reg == ST_LOCK_B) || v1_reg;

    ntsh_dist #(
        .TICK_BITS(TICK_BITS)
    ) u_dist (
        .aclk  (aclk),
        .en    (dist_en),
        .x     (dist_x),
        .y     (dist_y),
        .d_reg (dist_d)
    );

    // decisions
    assign issue      = (state_reg == ST_SCAN) && (cnt_reg < count_reg);
    assign pass_thru  = !snap_en_reg || (count_reg == '0) || (attract_reg == '0);
    assign la_ok      = (la_reg <= rel_ext);
    assign lb_ok      = (dist_d <= rel_ext);
    assign lock_hit   = la_ok || (pair_reg && lb_ok);
    assign lock_use_b = pair_reg && !(la_reg <= dist_d);
    assign found_now  = any_reg && (best_reg <= att_ext);
    assign fa         = pair_reg ? fa_reg : found_now;
    assign fb         = pair_reg && found_now;
    assign pick_a     = fa && (!fb || (da_reg <= best_reg));
    assign a_cand     = pair_reg ? ta_reg : hit_reg;
    assign win        = pick_a ? a_cand : hit_reg;

    // sequencer, scan pipeline, lock and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            lock_valid_reg <= 1'b0;
            lock_tick_reg  <= '0;
            lock_kind_reg  <= KIND_GRID;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            // result taken downstream, unless a new one is loaded this cycle
            if (m_tvalid_reg && m_tready && (state_reg != ST_EMIT)) begin
                m_tvalid_reg <= 1'b0;
            end

            // scan pipeline: read, distance, compare
            v1_reg <= issue;
            v2_reg <= v1_reg;
            if (issue) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (v1_reg) begin
                cand_reg <= mem_q_reg;
            end
            if (v2_reg && (!any_reg || (dist_d < best_reg))) begin
                any_reg  <= 1'b1;
                best_reg <= dist_d;
                hit_reg  <= cand_reg;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (in_acc) begin
                        a_reg     <= in_tick_a;
                        b_reg     <= in_tick_b;
                        pair_reg  <= (in_op == OP_SNAP_PAIR);
                        phase_reg <= 1'b0;
                        cnt_reg   <= '0;
                        any_reg   <= 1'b0;
                        case (in_op)
                            OP_CLEAR: count_reg <= '0;
                            OP_ADD: begin
                                if (mem_we) begin
                                    count_reg <= count_reg + 1'b1;
                                end
                            end
                            OP_LOCK_RESET: begin
                                lock_valid_reg <= 1'b0;
                                lock_tick_reg  <= '0;
                                lock_kind_reg  <= KIND_GRID;
                            end
                            OP_SNAP, OP_SNAP_PAIR: begin
                                if (pass_thru) begin
                                    snapped_reg <= 1'b0;
                                    state_reg   <= ST_EMIT;
                                end else if (lock_valid_reg) begin
                                    state_reg <= ST_LOCK_A;
                                end else begin
                                    state_reg <= ST_SCAN;
                                end
                            end
                            default: ;
                        endcase
                    end
                end

                ST_LOCK_A: state_reg <= ST_LOCK_B;

                ST_LOCK_B: begin
                    la_reg    <= dist_d;
                    state_reg <= ST_LOCK_CHK;
                end

                // stay on the lock inside the release zone, else drop it and scan
                ST_LOCK_CHK: begin
                    if (lock_hit) begin
                        sel_tick_reg <= lock_tick_reg;
                        sel_kind_reg <= lock_kind_reg;
                        use_b_reg    <= lock_use_b;
                        snapped_reg  <= 1'b1;
                        state_reg    <= ST_FIN;
                    end else begin
                        lock_valid_reg <= 1'b0;
                        lock_tick_reg  <= '0;
                        lock_kind_reg  <= KIND_GRID;
                        state_reg      <= ST_SCAN;
                    end
                end

                ST_SCAN: begin
                    if (!issue && !v1_reg && !v2_reg) begin
                        state_reg <= ST_SCAN_END;
                    end
                end

                // edge A result kept for a pair, then the winner, if any, is locked
                ST_SCAN_END: begin
                    if (pair_reg && !phase_reg) begin
                        fa_reg    <= found_now;
                        da_reg    <= best_reg;
                        ta_reg    <= hit_reg;
                        phase_reg <= 1'b1;
                        cnt_reg   <= '0;
                        any_reg   <= 1'b0;
                        state_reg <= ST_SCAN;
                    end else if (fa || fb) begin
                        lock_valid_reg <= 1'b1;
                        lock_tick_reg  <= win.tick;
                        lock_kind_reg  <= win.kind;
                        sel_tick_reg   <= win.tick;
                        sel_kind_reg   <= win.kind;
                        use_b_reg      <= !pick_a;
                        snapped_reg    <= 1'b1;
                        state_reg      <= ST_FIN;
                    end else begin
                        snapped_reg <= 1'b0;
                        state_reg   <= ST_EMIT;
                    end
                end

                // shift relative to the edge that snapped
                ST_FIN: begin
                    delta_reg <= sel_tick_reg - (use_b_reg ? b_reg : a_reg);
                    state_reg <= ST_EMIT;
                end

                ST_EMIT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        if (snapped_reg) begin
                            m_tdata_reg <= DATA_W'({delta_reg,
                                (use_b_reg ? a_reg + delta_reg : sel_tick_reg)});
                            m_tuser_reg <= {sel_kind_reg, 1'b1};
                        end else begin
                            m_tdata_reg <= DATA_W'(a_reg);
                            m_tuser_reg <= {KIND_GRID, 1'b0};
                        end
                        state_reg <= ST_IDLE;
                    end
                end

                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // checks
    `NTSH_ASSERT_NEXT(a_full_add_ignored, aclk, aresetn,
        in_acc && (in_op == OP_ADD) && (count_reg == CW'(MAX_TARGETS)),
        count_reg == CW'(MAX_TARGETS), "add request changed a full table")
    `NTSH_ASSERT_NOW(a_lock_set_after_scan, aclk, aresetn,
        $rose(lock_valid_reg), $past(state_reg) == ST_SCAN_END,
        "lock taken outside the end of a scan")
    `NTSH_ASSERT_NOW(a_scan_drained, aclk, aresetn,
        state_reg == ST_SCAN_END, !v1_reg && !v2_reg && (cnt_reg == count_reg),
        "scan ended with entries still in flight")

endmodule
